FILE: hdl/sgb_pkg.sv
// Shared types, sizes and helpers for the separable Gaussian blur stream unit.
// No dependencies; every other file refers to it by scoped names.
package sgb_pkg;

    // grid and kernel limits
    localparam int MAX_RADIUS  = 3;
    localparam int MAX_COLS    = 1024;
    localparam int MAX_ROWS    = 1024;
    localparam int STORE_DEPTH = (2 * MAX_RADIUS + 1) * MAX_COLS;

    // field and datapath widths
    localparam int VAL_W    = 16;
    localparam int TAP_W    = 16;
    localparam int RAD_W    = 2;
    localparam int DIM_W    = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int ADDR_W   = $clog2(STORE_DEPTH);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int CNT_W    = $clog2(MAX_COLS * MAX_ROWS + 1);
    localparam int REFF_W   = $clog2(MAX_RADIUS + 1);
    localparam int D_W      = REFF_W + 1;
    localparam int OFF_W    = ADDR_W + 2;
    localparam int PROD_W   = TAP_W + VAL_W;
    localparam int RSUM_W   = PROD_W + 4;
    localparam int RPROD_W  = TAP_W + RSUM_W;
    localparam int ACC_W    = RPROD_W + 4;
    localparam int FRAC_W   = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_CENTER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_ONE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_TWO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_THREE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS  = 3'd6;

    // input command codes
    localparam logic CMD_CELL  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic             command;
        logic [VAL_W-1:0] cell_value;
    } in_word_t;

    typedef struct packed {
        logic [VAL_W-1:0] blurred_value;
        logic             frame_end;
    } out_word_t;

    typedef struct packed {
        logic [TAP_W-1:0] center;
        logic [TAP_W-1:0] one;
        logic [TAP_W-1:0] two;
        logic [TAP_W-1:0] three;
    } taps_t;

    // kernel weight at a given distance; beyond three weighs zero
    function automatic logic [TAP_W-1:0] tap_weight(input taps_t taps,
                                                    input logic [D_W-1:0] tap_dist);
        logic [TAP_W-1:0] w;
        unique case (tap_dist)
            D_W'(0): w = taps.center;
            D_W'(1): w = taps.one;
            D_W'(2): w = taps.two;
            D_W'(3): w = taps.three;
            default: w = '0;
        endcase
        return w;
    endfunction

    // magnitude of a signed tap offset
    function automatic logic [D_W-1:0] abs_off(input logic signed [D_W-1:0] d);
        logic [D_W-1:0] m;
        m = d[D_W-1] ? D_W'(-d) : D_W'(d);
        return m;
    endfunction

    // clamp a grid dimension to 1..hi
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] c;
        if (v == '0) begin
            c = DIM_W'(1);
        end else if (v > hi) begin
            c = hi;
        end else begin
            c = v;
        end
        return c;
    endfunction

endpackage

FILE: hdl/sgb_row_store.sv
// Circular cell store of the blur unit: one write and one registered read port.
// Depends on sgb_pkg for depth and widths.
module sgb_row_store (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [sgb_pkg::ADDR_W-1:0] wr_addr,
    input  logic [sgb_pkg::VAL_W-1:0]  wr_data,
    input  logic                       rd_en,
    input  logic [sgb_pkg::ADDR_W-1:0] rd_addr,
    output logic [sgb_pkg::VAL_W-1:0]  rd_data
);

    logic [sgb_pkg::VAL_W-1:0] mem [sgb_pkg::STORE_DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/sgb_divider.sv
// Restoring divider, one quotient bit per cycle: splits an output index into row and column.
// Depends on sgb_pkg for the counter and dimension widths.
module sgb_divider (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [sgb_pkg::CNT_W-1:0] dividend,
    input  logic [sgb_pkg::DIM_W-1:0] divisor,
    output logic                      done,
    output logic [sgb_pkg::CNT_W-1:0] quotient,
    output logic [sgb_pkg::DIM_W-1:0] remainder
);

    localparam int STEP_W = $clog2(sgb_pkg::CNT_W + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(sgb_pkg::CNT_W - 1);

    logic                      busy_reg;
    logic                      done_reg;
    logic [STEP_W-1:0]         step_reg;
    logic [sgb_pkg::CNT_W-1:0] q_reg;
    logic [sgb_pkg::DIM_W-1:0] rem_reg;
    logic [sgb_pkg::DIM_W:0]   rem_sh;
    logic                      ge;
    logic [sgb_pkg::DIM_W-1:0] rem_next;

    // shift in the next dividend bit and try the subtract
    always_comb begin
        rem_sh   = {rem_reg, q_reg[sgb_pkg::CNT_W-1]};
        ge       = rem_sh >= {1'b0, divisor};
        rem_next = ge ? sgb_pkg::DIM_W'(rem_sh - {1'b0, divisor})
                      : rem_sh[sgb_pkg::DIM_W-1:0];
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= busy_reg && (step_reg == LAST_STEP);
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[sgb_pkg::CNT_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = rem_reg;

endmodule

FILE: hdl/separable_gaussian_blur_stream_unit.sv
// One word is in flight at a time; the rate is set by the single store read port, taken
// once per in-grid kernel tap, and the serial row/column divide of the output index.
// Reset (aresetn low, synchronous): registers return to their defaults, counts clear;
// the cell store is not cleared and needs no clearing pass.
module separable_gaussian_blur_stream_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  sgb_pkg::in_word_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output sgb_pkg::out_word_t            m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sgb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sgb_pkg::CFG_DAT_W-1:0] cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_START  = 4'd1;
    localparam logic [3:0] S_STORE  = 4'd2;
    localparam logic [3:0] S_DIV    = 4'd3;
    localparam logic [3:0] S_NEED   = 4'd4;
    localparam logic [3:0] S_TEST   = 4'd5;
    localparam logic [3:0] S_RD     = 4'd6;
    localparam logic [3:0] S_MUL    = 4'd7;
    localparam logic [3:0] S_ACC    = 4'd8;
    localparam logic [3:0] S_ROWMUL = 4'd9;
    localparam logic [3:0] S_ROWACC = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    localparam int ADDR_W = sgb_pkg::ADDR_W;
    localparam int CNT_W  = sgb_pkg::CNT_W;
    localparam int DIM_W  = sgb_pkg::DIM_W;
    localparam int D_W    = sgb_pkg::D_W;
    localparam int OFF_W  = sgb_pkg::OFF_W;
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(sgb_pkg::STORE_DEPTH - 1);
    localparam logic [DIM_W-1:0]  COLS_HI   = DIM_W'(sgb_pkg::MAX_COLS);
    localparam logic [DIM_W-1:0]  ROWS_HI   = DIM_W'(sgb_pkg::MAX_ROWS);
    localparam int RES_W = sgb_pkg::ACC_W + 1 - sgb_pkg::FRAC_W;

    // configuration registers
    logic [sgb_pkg::RAD_W-1:0] radius_reg;
    sgb_pkg::taps_t            taps_reg;
    logic [DIM_W-1:0]          grid_cols_reg;
    logic [DIM_W-1:0]          grid_rows_reg;

    // control and counters
    logic [3:0]        state_reg;
    sgb_pkg::in_word_t item_reg;
    logic [CNT_W-1:0]  in_count_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [CNT_W-1:0]  total_reg;
    logic [CNT_W:0]    need_reg;
    logic [sgb_pkg::ROW_W-1:0] oi_reg;
    logic [sgb_pkg::COL_W-1:0] oj_reg;

    // tap loop
    logic signed [D_W-1:0]   di_reg;
    logic signed [D_W-1:0]   dj_reg;
    logic signed [OFF_W-1:0] roff_reg;
    logic [sgb_pkg::PROD_W-1:0]  prod_reg;
    logic [sgb_pkg::RSUM_W-1:0]  rowsum_reg;
    logic [sgb_pkg::RPROD_W-1:0] rprod_reg;
    logic [sgb_pkg::ACC_W-1:0]   acc_reg;

    // output register
    logic               m_valid_reg;
    sgb_pkg::out_word_t m_data_reg;

    // effective sizes
    logic [DIM_W-1:0]              cols_eff;
    logic [DIM_W-1:0]              rows_eff;
    logic [sgb_pkg::REFF_W-1:0]    r_eff;
    logic signed [D_W-1:0]         r_s;

    // store and divider hookup
    logic                       mem_wr_en;
    logic                       mem_rd_en;
    logic [ADDR_W-1:0]          mem_rd_addr;
    logic [sgb_pkg::VAL_W-1:0]  mem_rd_data;
    logic                       div_start;
    logic                       div_done;
    logic [CNT_W-1:0]           div_q;
    logic [DIM_W-1:0]           div_rem;

    // per tap combinational values
    logic signed [sgb_pkg::ROW_W+1:0] ii;
    logic signed [sgb_pkg::COL_W+1:0] jj;
    logic                             tap_ok;
    logic signed [OFF_W-1:0]          tap_sum;
    logic [ADDR_W-1:0]                tap_addr;
    logic [sgb_pkg::ROW_W:0]          nr;
    logic [sgb_pkg::COL_W:0]          nc;
    logic [sgb_pkg::ACC_W:0]          rounded;
    logic [RES_W-1:0]                 res;
    logic                             out_free;
    logic [CNT_W-1:0]                 out_count_inc;
    logic [ADDR_W+sgb_pkg::REFF_W-1:0] rcols;

    assign cols_eff = sgb_pkg::clamp_dim(grid_cols_reg, COLS_HI);
    assign rows_eff = sgb_pkg::clamp_dim(grid_rows_reg, ROWS_HI);
    assign r_eff = (radius_reg > sgb_pkg::RAD_W'(sgb_pkg::MAX_RADIUS))
                   ? sgb_pkg::REFF_W'(sgb_pkg::MAX_RADIUS)
                   : sgb_pkg::REFF_W'(radius_reg);
    assign r_s = $signed({1'b0, r_eff});

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign out_count_inc = out_count_reg + CNT_W'(1);

    assign mem_wr_en = (state_reg == S_STORE) && (item_reg.command == sgb_pkg::CMD_CELL)
                       && (in_count_reg < total_reg);
    assign div_start = (state_reg == S_STORE);

    // tap position, range check and wrapped store address
    always_comb begin
        ii = $signed({2'b0, oi_reg}) + (sgb_pkg::ROW_W + 2)'(di_reg);
        jj = $signed({2'b0, oj_reg}) + (sgb_pkg::COL_W + 2)'(dj_reg);
        tap_ok = (ii >= 0) && (ii < $signed({1'b0, rows_eff}))
                 && (jj >= 0) && (jj < $signed({1'b0, cols_eff}));
        tap_sum = $signed({2'b0, out_addr_reg}) + roff_reg + OFF_W'(dj_reg);
        if (tap_sum < 0) begin
            tap_addr = ADDR_W'(tap_sum + OFF_W'(sgb_pkg::STORE_DEPTH));
        end else if (tap_sum > $signed({2'b0, ADDR_LAST})) begin
            tap_addr = ADDR_W'(tap_sum - OFF_W'(sgb_pkg::STORE_DEPTH));
        end else begin
            tap_addr = ADDR_W'(tap_sum);
        end
    end

    assign mem_rd_en   = (state_reg == S_RD) && tap_ok;
    assign mem_rd_addr = tap_addr;

    // readiness corner: last cell that output's window needs
    always_comb begin
        nr = {1'b0, oi_reg} + (sgb_pkg::ROW_W + 1)'(r_eff);
        if (nr > (sgb_pkg::ROW_W + 1)'(rows_eff - DIM_W'(1))) begin
            nr = (sgb_pkg::ROW_W + 1)'(rows_eff - DIM_W'(1));
        end
        nc = {1'b0, oj_reg} + (sgb_pkg::COL_W + 1)'(r_eff);
        if (nc > (sgb_pkg::COL_W + 1)'(cols_eff - DIM_W'(1))) begin
            nc = (sgb_pkg::COL_W + 1)'(cols_eff - DIM_W'(1));
        end
    end

    // round half up; the result saturates when the output word is loaded
    always_comb begin
        rounded = {1'b0, acc_reg} + (sgb_pkg::ACC_W + 1)'(64'h8000_0000);
        res     = rounded[sgb_pkg::ACC_W:sgb_pkg::FRAC_W];
    end

    assign rcols = (ADDR_W + sgb_pkg::REFF_W)'(r_eff * cols_eff);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg      <= sgb_pkg::RAD_W'(1);
            taps_reg.center <= 16'hFFFF;
            taps_reg.one    <= '0;
            taps_reg.two    <= '0;
            taps_reg.three  <= '0;
            grid_cols_reg   <= COLS_HI;
            grid_rows_reg   <= ROWS_HI;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                sgb_pkg::CFG_RADIUS:     radius_reg      <= cfg_data[sgb_pkg::RAD_W-1:0];
                sgb_pkg::CFG_TAP_CENTER: taps_reg.center <= cfg_data;
                sgb_pkg::CFG_TAP_ONE:    taps_reg.one    <= cfg_data;
                sgb_pkg::CFG_TAP_TWO:    taps_reg.two    <= cfg_data;
                sgb_pkg::CFG_TAP_THREE:  taps_reg.three  <= cfg_data;
                sgb_pkg::CFG_GRID_COLS:  grid_cols_reg   <= cfg_data[DIM_W-1:0];
                sgb_pkg::CFG_GRID_ROWS:  grid_rows_reg   <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // frame size, registered off the multiplier
    always_ff @(posedge aclk) begin
        total_reg <= CNT_W'(cols_eff * rows_eff);
    end

    // sequencer; the store is written before any read of the same word, so no overlap
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            in_count_reg  <= '0;
            out_count_reg <= '0;
            wr_addr_reg   <= '0;
            out_addr_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            // drop the taken word unless a new one is loaded this cycle
            if (m_valid_reg && m_ready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        item_reg  <= s_data;
                        state_reg <= S_START;
                    end
                end
                S_START: begin
                    // drop a finished or oversized frame
                    if ((out_count_reg >= total_reg) || (in_count_reg > total_reg)) begin
                        in_count_reg  <= '0;
                        out_count_reg <= '0;
                        wr_addr_reg   <= '0;
                        out_addr_reg  <= '0;
                    end
                    state_reg <= S_STORE;
                end
                S_STORE: begin
                    if (mem_wr_en) begin
                        in_count_reg <= in_count_reg + CNT_W'(1);
                        wr_addr_reg  <= (wr_addr_reg == ADDR_LAST) ? '0
                                        : wr_addr_reg + ADDR_W'(1);
                    end
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        oi_reg    <= sgb_pkg::ROW_W'(div_q);
                        oj_reg    <= sgb_pkg::COL_W'(div_rem);
                        state_reg <= S_NEED;
                    end
                end
                S_NEED: begin
                    need_reg  <= (CNT_W + 1)'(nr * cols_eff) + (CNT_W + 1)'(nc);
                    state_reg <= S_TEST;
                end
                S_TEST: begin
                    if (need_reg >= {1'b0, in_count_reg}) begin
                        state_reg <= S_IDLE;
                    end else begin
                        di_reg     <= -r_s;
                        dj_reg     <= -r_s;
                        roff_reg   <= -$signed(OFF_W'(rcols));
                        rowsum_reg <= '0;
                        acc_reg    <= '0;
                        state_reg  <= S_RD;
                    end
                end
                S_RD: begin
                    if (tap_ok) begin
                        state_reg <= S_MUL;
                    end else if (dj_reg == r_s) begin
                        state_reg <= S_ROWMUL;
                    end else begin
                        dj_reg <= dj_reg + D_W'(1);
                    end
                end
                S_MUL: begin
                    prod_reg  <= sgb_pkg::tap_weight(taps_reg, sgb_pkg::abs_off(dj_reg))
                                 * mem_rd_data;
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    rowsum_reg <= rowsum_reg + sgb_pkg::RSUM_W'(prod_reg);
                    if (dj_reg == r_s) begin
                        state_reg <= S_ROWMUL;
                    end else begin
                        dj_reg    <= dj_reg + D_W'(1);
                        state_reg <= S_RD;
                    end
                end
                S_ROWMUL: begin
                    rprod_reg <= sgb_pkg::tap_weight(taps_reg, sgb_pkg::abs_off(di_reg))
                                 * rowsum_reg;
                    state_reg <= S_ROWACC;
                end
                S_ROWACC: begin
                    acc_reg    <= acc_reg + sgb_pkg::ACC_W'(rprod_reg);
                    rowsum_reg <= '0;
                    if (di_reg == r_s) begin
                        state_reg <= S_DONE;
                    end else begin
                        di_reg    <= di_reg + D_W'(1);
                        dj_reg    <= -r_s;
                        roff_reg  <= roff_reg + OFF_W'(cols_eff);
                        state_reg <= S_RD;
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg.blurred_value <= (res > RES_W'(16'hFFFF)) ? 16'hFFFF
                                                    : sgb_pkg::VAL_W'(res);
                        if (out_count_inc >= total_reg) begin
                            m_data_reg.frame_end <= 1'b1;
                            in_count_reg  <= '0;
                            out_count_reg <= '0;
                            wr_addr_reg   <= '0;
                            out_addr_reg  <= '0;
                        end else begin
                            m_data_reg.frame_end <= 1'b0;
                            out_count_reg <= out_count_inc;
                            out_addr_reg  <= (out_addr_reg == ADDR_LAST) ? '0
                                             : out_addr_reg + ADDR_W'(1);
                        end
                        state_reg <= S_IDLE;
                    end else if (m_valid_reg && m_ready) begin
                        m_valid_reg <= 1'b0;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    sgb_row_store u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (wr_addr_reg),
        .wr_data (item_reg.cell_value),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    sgb_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (out_count_reg),
        .divisor   (cols_eff),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_rem)
    );

`ifndef NO_ASSERTIONS
    // outputs never run ahead of the cells taken in
    a_out_le_in: assert property (@(posedge aclk) disable iff (!aresetn)
        out_count_reg <= in_count_reg)
        else $error("output count passed input count");

    // the divider only finishes while the sequencer waits for it
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside its wait state");

    // a frame end word leaves both counts cleared
    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && out_free && out_count_inc >= total_reg)
        |=> (in_count_reg == '0 && out_count_reg == '0 && m_data_reg.frame_end))
        else $error("counts not cleared at frame end");

    // store writes stay within the frame
    a_write_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |=> (in_count_reg <= total_reg))
        else $error("cell stored beyond the frame");
`endif

endmodule

FILE: test/tb.sv
// Self-checking testbench for separable_gaussian_blur_stream_unit.
// Depends on sgb_pkg and the unit; predicts each blurred word and checks it in order.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 250;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    sgb_pkg::in_word_t             s_data;
    logic                          m_valid;
    logic                          m_ready;
    sgb_pkg::out_word_t            m_data;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [sgb_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [sgb_pkg::CFG_DAT_W-1:0] cfg_data;

    separable_gaussian_blur_stream_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the unit's registers and frame state
    logic [sgb_pkg::RAD_W-1:0] kern_radius;
    sgb_pkg::taps_t            kern_taps;
    logic [sgb_pkg::DIM_W-1:0] cols_reg;
    logic [sgb_pkg::DIM_W-1:0] rows_reg;
    logic [sgb_pkg::VAL_W-1:0] cell_mem [sgb_pkg::STORE_DEPTH];
    int unsigned               cells_in;
    int unsigned               cells_out;

    sgb_pkg::in_word_t  pending_words[$];
    sgb_pkg::out_word_t blurred_expected[$];
    int        send_idle_pct;
    int        recv_stall_pct;
    int        mismatch_count;
    int        words_sent;

    // clock and single reset
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #60_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic longint unsigned kern_weight(int d);
        longint unsigned w;
        if (d < 0) d = -d;
        case (d)
            0: w = kern_taps.center;
            1: w = kern_taps.one;
            2: w = kern_taps.two;
            3: w = kern_taps.three;
            default: w = 0;
        endcase
        return w;
    endfunction

    function automatic int unsigned dim_limit(logic [sgb_pkg::DIM_W-1:0] v, int unsigned hi);
        int unsigned d;
        d = v;
        if (d < 1) d = 1;
        if (d > hi) d = hi;
        return d;
    endfunction

    // advance the blur state by one word, queue the blurred cell if one is ready
    function automatic void blur_accept(sgb_pkg::in_word_t w);
        int unsigned        cols, rows, total, r, oi, oj, need, idx;
        int                 ii, jj;
        longint unsigned    acc, rowsum, res;
        sgb_pkg::out_word_t o;
        cols  = dim_limit(cols_reg, sgb_pkg::MAX_COLS);
        rows  = dim_limit(rows_reg, sgb_pkg::MAX_ROWS);
        total = cols * rows;
        r     = kern_radius;
        acc   = 0;
        if (cells_out >= total || cells_in > total) begin
            cells_in  = 0;
            cells_out = 0;
        end
        if (w.command == sgb_pkg::CMD_CELL && cells_in < total) begin
            cell_mem[cells_in % sgb_pkg::STORE_DEPTH] = w.cell_value;
            cells_in++;
        end
        oi   = cells_out / cols;
        oj   = cells_out % cols;
        need = ((oi + r < rows - 1) ? oi + r : rows - 1) * cols
             + ((oj + r < cols - 1) ? oj + r : cols - 1);
        if (need >= cells_in) return;
        for (int di = -int'(r); di <= int'(r); di++) begin
            ii = int'(oi) + di;
            rowsum = 0;
            if (ii < 0 || ii >= int'(rows)) continue;
            for (int dj = -int'(r); dj <= int'(r); dj++) begin
                jj = int'(oj) + dj;
                if (jj < 0 || jj >= int'(cols)) continue;
                idx = (ii * cols + jj) % sgb_pkg::STORE_DEPTH;
                rowsum += kern_weight(dj) * cell_mem[idx];
            end
            acc += kern_weight(di) * rowsum;
        end
        res = (acc + 64'h8000_0000) >> 32;
        if (res > 65535) res = 65535;
        o.blurred_value = res[sgb_pkg::VAL_W-1:0];
        cells_out++;
        o.frame_end = (cells_out >= total);
        if (o.frame_end) begin
            cells_in  = 0;
            cells_out = 0;
        end
        blurred_expected.push_back(o);
    endfunction

    // input driver: hold the word until taken, then maybe idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            if (s_valid && s_ready) blur_accept(s_data);
            if (!s_valid || s_ready) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_data  <= pending_words.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: compare each taken word with the oldest expectation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (blurred_expected.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected word: value %0d end %0b",
                                 m_data.blurred_value, m_data.frame_end);
                end else begin
                    sgb_pkg::out_word_t e;
                    e = blurred_expected.pop_front();
                    if (e.blurred_value !== m_data.blurred_value ||
                        e.frame_end !== m_data.frame_end) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("blur mismatch: expected %0d/%0b got %0d/%0b",
                                     e.blurred_value, e.frame_end,
                                     m_data.blurred_value, m_data.frame_end);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic wait_quiet();
        int guard;
        guard = 0;
        while ((pending_words.size() > 0 || s_valid || blurred_expected.size() > 0)
               && guard < 200_000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(logic [sgb_pkg::CFG_IDX_W-1:0] idx,
                             logic [sgb_pkg::CFG_DAT_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            sgb_pkg::CFG_RADIUS:     kern_radius      = val[sgb_pkg::RAD_W-1:0];
            sgb_pkg::CFG_TAP_CENTER: kern_taps.center = val;
            sgb_pkg::CFG_TAP_ONE:    kern_taps.one    = val;
            sgb_pkg::CFG_TAP_TWO:    kern_taps.two    = val;
            sgb_pkg::CFG_TAP_THREE:  kern_taps.three  = val;
            sgb_pkg::CFG_GRID_COLS:  cols_reg         = val[sgb_pkg::DIM_W-1:0];
            sgb_pkg::CFG_GRID_ROWS:  rows_reg         = val[sgb_pkg::DIM_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic load_kernel(int r, int c0, int c1, int c2, int c3, int cols, int rows);
        reg_write(sgb_pkg::CFG_RADIUS, sgb_pkg::CFG_DAT_W'(r));
        reg_write(sgb_pkg::CFG_TAP_CENTER, sgb_pkg::CFG_DAT_W'(c0));
        reg_write(sgb_pkg::CFG_TAP_ONE, sgb_pkg::CFG_DAT_W'(c1));
        reg_write(sgb_pkg::CFG_TAP_TWO, sgb_pkg::CFG_DAT_W'(c2));
        reg_write(sgb_pkg::CFG_TAP_THREE, sgb_pkg::CFG_DAT_W'(c3));
        reg_write(sgb_pkg::CFG_GRID_COLS, sgb_pkg::CFG_DAT_W'(cols));
        reg_write(sgb_pkg::CFG_GRID_ROWS, sgb_pkg::CFG_DAT_W'(rows));
    endtask

    function automatic void push_word(logic cmd, logic [sgb_pkg::VAL_W-1:0] v);
        sgb_pkg::in_word_t w;
        w.command    = cmd;
        w.cell_value = v;
        pending_words.push_back(w);
        words_sent++;
    endfunction

    function automatic logic [sgb_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return sgb_pkg::VAL_W'($urandom);
        endcase
    endfunction

    function automatic int pick_tap();
        case ($urandom_range(7))
            0: return 0;
            1: return 65535;
            default: return $urandom_range(65535);
        endcase
    endfunction

    function automatic void set_idling(int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
        endcase
    endfunction

    initial begin
        int phase, cols, rows, r, ncells, ndrain;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        kern_radius = sgb_pkg::RAD_W'(1);
        kern_taps   = '{center: 16'hFFFF, one: 16'h0, two: 16'h0, three: 16'h0};
        cols_reg  = sgb_pkg::DIM_W'(1024);
        rows_reg  = sgb_pkg::DIM_W'(1024);
        cells_in  = 0;
        cells_out = 0;
        mismatch_count = 0;
        words_sent = 0;
        set_idling(0);
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults: partial frame on the full grid, then a drain with nothing ready
        push_word(sgb_pkg::CMD_CELL, 16'h0000);
        push_word(sgb_pkg::CMD_CELL, 16'hFFFF);
        push_word(sgb_pkg::CMD_CELL, 16'h8000);
        push_word(sgb_pkg::CMD_DRAIN, 16'h1234);
        wait_quiet();

        // sizes of zero count as one, dropping the partial frame
        reg_write(sgb_pkg::CFG_GRID_COLS, '0);
        reg_write(sgb_pkg::CFG_GRID_ROWS, '0);
        push_word(sgb_pkg::CMD_CELL, 16'hFFFF);
        push_word(sgb_pkg::CMD_DRAIN, 16'h0000);
        push_word(sgb_pkg::CMD_CELL, 16'h0001);
        wait_quiet();

        // widest kernel, full taps, oversize width: saturation
        load_kernel(3, 65535, 65535, 65535, 65535, 2047, 1);
        repeat (6) push_word(sgb_pkg::CMD_CELL, 16'hFFFF);
        wait_quiet();

        // full small frame, a cell past the end acting as a drain, then drains
        load_kernel(2, 40000, 12000, 3000, 65535, 4, 3);
        for (int i = 0; i < 12; i++) push_word(sgb_pkg::CMD_CELL, pick_value());
        push_word(sgb_pkg::CMD_CELL, 16'hFFFF);
        repeat (10) push_word(sgb_pkg::CMD_DRAIN, 16'h0);
        wait_quiet();

        // random frames
        phase = 0;
        while (words_sent < 1850) begin
            phase++;
            set_idling(phase);
            r = $urandom_range(3);
            case ($urandom_range(19))
                0: begin cols = 1024; rows = 1; end
                1: begin cols = 1; rows = ($urandom_range(1)) ? 1024 : 2047; end
                2: begin cols = 0; rows = $urandom_range(6); end
                3: begin cols = 2047; rows = 1; end
                default: begin cols = $urandom_range(1, 9); rows = $urandom_range(1, 7); end
            endcase
            load_kernel(r, pick_tap(), pick_tap(), pick_tap(), pick_tap(), cols, rows);
            ncells = dim_limit(sgb_pkg::DIM_W'(cols), sgb_pkg::MAX_COLS)
                   * dim_limit(sgb_pkg::DIM_W'(rows), sgb_pkg::MAX_ROWS);
            ndrain = r * dim_limit(sgb_pkg::DIM_W'(cols), sgb_pkg::MAX_COLS) + r + 2;
            if (ncells > 40) begin
                ncells = $urandom_range(5, 40);
                ndrain = 3;
            end else if ($urandom_range(9) == 0) begin
                // broken frame: cut short, noise drains
                ncells = $urandom_range(ncells);
                ndrain = $urandom_range(3);
            end
            for (int i = 0; i < ncells; i++) begin
                if ($urandom_range(19) == 0)
                    push_word(sgb_pkg::CMD_DRAIN, sgb_pkg::VAL_W'($urandom));
                push_word(sgb_pkg::CMD_CELL, pick_value());
            end
            repeat (ndrain) push_word(sgb_pkg::CMD_DRAIN, sgb_pkg::VAL_W'($urandom));
            wait_quiet();
        end

        if (blurred_expected.size() > 0) mismatch_count++;
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
